// ===== hdl/lbtc_pkg.sv =====
// ============================================================================
// lbtc_pkg: shared types and constants for the load board tilt command block
// Field widths, register indexes, sequencer states and divider job tags.
// ============================================================================
package lbtc_pkg;

    // Field widths
    localparam int CELL_W     = 16;                 // one load-cell weight
    localparam int OUT_W      = 19;                 // every result field, signed Q.F
    localparam int DB_W       = 16;                 // deadband registers
    localparam int GAIN_W     = 4;                  // gain registers
    localparam int ZB_W       = 16;                 // zero band register
    localparam int OFS_W      = 18;                 // signed dx / dy
    localparam int MAG_W      = 17;                 // |dx|, |dy|
    localparam int TOTAL_W    = 18;                 // w0+w1+w2+w3
    localparam int PROD_W     = GAIN_W + MAG_W;     // gain * |offset|
    localparam int DVS_W      = TOTAL_W + 2;        // 4 * total
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int S_DATA_W = ((4 * CELL_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((4 * OUT_W + 7) / 8) * 8;

    // Largest result magnitude before sign is applied, and the positive limit
    localparam logic [OUT_W:0]          SAT_MAG = (OUT_W + 1)'(1) << (OUT_W - 1);
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

    // Configuration register indexes
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
    localparam cfg_addr_t REG_X_DEADBAND = 3'd0;
    localparam cfg_addr_t REG_Y_DEADBAND = 3'd1;
    localparam cfg_addr_t REG_X_GAIN     = 3'd2;
    localparam cfg_addr_t REG_Y_GAIN     = 3'd3;
    localparam cfg_addr_t REG_ZERO_BAND  = 3'd4;

    // Register defaults
    localparam logic [DB_W-1:0]   X_DEADBAND_RST = 16'd200;
    localparam logic [DB_W-1:0]   Y_DEADBAND_RST = 16'd200;
    localparam logic [GAIN_W-1:0] X_GAIN_RST     = 4'd5;
    localparam logic [GAIN_W-1:0] Y_GAIN_RST     = 4'd12;
    localparam logic [ZB_W-1:0]   ZERO_BAND_RST  = 16'd655;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TX,
        ST_TY,
        ST_XPUSH,
        ST_XAVG,
        ST_YPUSH,
        ST_YAVG,
        ST_DIV,
        ST_STORE,
        ST_FINISH
    } lbtc_state_t;

    typedef enum logic [1:0] {
        JOB_TX,
        JOB_TY,
        JOB_XA,
        JOB_YA
    } lbtc_job_t;

endpackage

// ===== hdl/load_board_tilt_command.sv =====
// ============================================================================
// load_board_tilt_command: tilt ratios and windowed averages from four cells
// Forms x/y tilt ratios from four load-cell weights and keeps sliding-window
// averages of both, with deadband, gain, sign coupling and a zero band.
// ============================================================================
// s_axis_tready is high only in idle: a new request is taken only once the last
// result is committed to the result register, which waits while a held result stalls.
// The shared restoring divider makes one quotient bit per cycle, in 19 steps
// plus load and store, up to four divisions per request.
// Reset (aresetn low, synchronous): clears windows, sums and averages, loads
// the register defaults and drops m_axis_tvalid; no clearing pass.
module load_board_tilt_command #(
    parameter int X_WINDOW      = 20,
    parameter int Y_WINDOW      = 10,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration write port
    input  logic                                  cfg_we,
    input  logic [lbtc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [lbtc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // Request channel
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // load_cell_0 [15:0], load_cell_1 [31:16], load_cell_2 [47:32],
    // load_cell_3 [63:48]
    input  logic [lbtc_pkg::S_DATA_W-1:0]         s_axis_tdata,
    // Result channel
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // x_tilt [18:0], y_tilt [37:19], x_average [56:38], y_average [75:57],
    // zero [79:76]
    output logic [lbtc_pkg::M_DATA_W-1:0]         m_axis_tdata
);

    localparam int OUT_W   = lbtc_pkg::OUT_W;
    localparam int DVS_W   = lbtc_pkg::DVS_W;
    localparam int CELL_W  = lbtc_pkg::CELL_W;

    // Window sums: one output value times the window depth
    localparam int XS_W    = OUT_W + $clog2(X_WINDOW);
    localparam int YS_W    = OUT_W + $clog2(Y_WINDOW);
    localparam int SUMS_W  = (XS_W > YS_W) ? XS_W : YS_W;
    localparam int XA_W    = (X_WINDOW > 1) ? $clog2(X_WINDOW) : 1;
    localparam int YA_W    = (Y_WINDOW > 1) ? $clog2(Y_WINDOW) : 1;
    localparam int XF_W    = $clog2(X_WINDOW + 1);
    localparam int YF_W    = $clog2(Y_WINDOW + 1);

    // Divider numerator: gain*|offset| shifted by the fraction, or a window sum
    localparam int TN_W    = lbtc_pkg::PROD_W + FRACTION_BITS;
    localparam int NUM_W   = (TN_W > SUMS_W) ? TN_W : SUMS_W;
    localparam int HI_W    = NUM_W - OUT_W;
    localparam int CMP_W   = (HI_W > DVS_W) ? HI_W : DVS_W;
    localparam int CNT_W   = $clog2(OUT_W);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    lbtc_pkg::lbtc_state_t state_reg, state_next;
    lbtc_pkg::lbtc_job_t   job_reg, job_next;

    logic [lbtc_pkg::DB_W-1:0]   x_db_reg, y_db_reg;
    logic [lbtc_pkg::GAIN_W-1:0] x_gain_reg, y_gain_reg;
    logic [lbtc_pkg::ZB_W-1:0]   zb_reg;

    logic signed [lbtc_pkg::OFS_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [lbtc_pkg::TOTAL_W-1:0]      total_reg, total_next;

    // Shared divider
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [OUT_W-1:0] lo_reg, lo_next;
    logic [OUT_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;

    logic signed [OUT_W-1:0] xt_reg, xt_next, yt_reg, yt_next;
    logic signed [OUT_W-1:0] xh_reg, xh_next, yh_reg, yh_next;

    // Windows
    logic signed [XS_W-1:0] xsum_reg, xsum_next;
    logic signed [YS_W-1:0] ysum_reg, ysum_next;
    logic [XF_W-1:0]        xfill_reg, xfill_next;
    logic [YF_W-1:0]        yfill_reg, yfill_next;
    logic [XA_W-1:0]        xold_reg, xold_next;
    logic [YA_W-1:0]        yold_reg, yold_next;
    logic signed [OUT_W-1:0] xrd_reg, yrd_reg;
    logic signed [OUT_W-1:0] xmem [X_WINDOW];
    logic signed [OUT_W-1:0] ymem [Y_WINDOW];
    logic                   x_we, y_we;
    logic [XA_W-1:0]        x_waddr;
    logic [YA_W-1:0]        y_waddr;

    // Result register
    logic                             m_valid_reg, m_valid_next;
    logic [lbtc_pkg::M_DATA_W-1:0]    m_data_reg, m_data_next;

    // ------------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------------
    logic [CELL_W-1:0] w0, w1, w2, w3;
    logic              in_fire;
    logic              out_free;

    // Tilt operands for whichever axis is being started
    logic                          t_is_x;
    logic [lbtc_pkg::MAG_W-1:0]    dx_mag, dy_mag, t_mag;
    logic [lbtc_pkg::GAIN_W-1:0]   t_gain;
    logic [lbtc_pkg::DB_W-1:0]     t_db;
    logic                          t_neg, t_pass;
    logic [lbtc_pkg::PROD_W-1:0]   t_prod;

    // Average operands
    logic signed [SUMS_W-1:0] a_sum;
    logic [SUMS_W-1:0]        a_mag;
    logic [DVS_W-1:0]         a_dvs;

    // Divider start
    logic [NUM_W-1:0] st_num;
    logic [DVS_W-1:0] st_dvs;
    logic             st_neg;
    logic [CMP_W-1:0] st_hi;
    logic             st_ovf;

    // Divider step and store
    logic [DVS_W:0]          rem2;
    logic                    step_ge;
    logic [OUT_W:0]          q_mag;
    logic signed [OUT_W-1:0] div_res;

    // Final coupling and zero band
    logic signed [OUT_W-1:0] y_cpl;
    logic signed [OUT_W-1:0] xh_fin, yh_fin;

    function automatic logic [OUT_W:0] mag_of(input logic signed [OUT_W-1:0] v);
        logic signed [OUT_W:0] e;
        e = (OUT_W + 1)'(v);
        return v[OUT_W-1] ? (OUT_W + 1)'(-e) : (OUT_W + 1)'(e);
    endfunction

    assign w0 = s_axis_tdata[CELL_W-1:0];
    assign w1 = s_axis_tdata[2*CELL_W-1:CELL_W];
    assign w2 = s_axis_tdata[3*CELL_W-1:2*CELL_W];
    assign w3 = s_axis_tdata[4*CELL_W-1:3*CELL_W];

    assign s_axis_tready = (state_reg == lbtc_pkg::ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Offsets and the deadband test
    assign dx_mag = dx_reg[lbtc_pkg::OFS_W-1] ? lbtc_pkg::MAG_W'(-dx_reg)
                                              : lbtc_pkg::MAG_W'(dx_reg);
    assign dy_mag = dy_reg[lbtc_pkg::OFS_W-1] ? lbtc_pkg::MAG_W'(-dy_reg)
                                              : lbtc_pkg::MAG_W'(dy_reg);
    assign t_is_x = (state_reg == lbtc_pkg::ST_TX);
    assign t_mag  = t_is_x ? dx_mag : dy_mag;
    assign t_gain = t_is_x ? x_gain_reg : y_gain_reg;
    assign t_db   = t_is_x ? x_db_reg : y_db_reg;
    assign t_neg  = t_is_x ? dx_reg[lbtc_pkg::OFS_W-1] : dy_reg[lbtc_pkg::OFS_W-1];
    assign t_pass = ({1'b0, t_mag} > {t_db, 2'b00}) && (total_reg != '0);
    assign t_prod = lbtc_pkg::PROD_W'(t_gain) * lbtc_pkg::PROD_W'(t_mag);

    // Window sum magnitude and sign for the axis being averaged
    assign a_sum = (state_reg == lbtc_pkg::ST_XAVG) ? SUMS_W'(xsum_reg) : SUMS_W'(ysum_reg);
    assign a_mag = a_sum[SUMS_W-1] ? SUMS_W'(-a_sum) : SUMS_W'(a_sum);
    assign a_dvs = (state_reg == lbtc_pkg::ST_XAVG) ? DVS_W'(X_WINDOW) : DVS_W'(Y_WINDOW);

    // Divider load: tilt ratio or window average
    always_comb begin
        if (state_reg == lbtc_pkg::ST_XAVG || state_reg == lbtc_pkg::ST_YAVG) begin
            st_num = NUM_W'(a_mag);
            st_dvs = a_dvs;
            st_neg = a_sum[SUMS_W-1];
        end else begin
            st_num = NUM_W'({t_prod, {FRACTION_BITS{1'b0}}});
            st_dvs = {total_reg, 2'b00};
            st_neg = t_neg;
        end
    end

    // Quotient would not fit in OUT_W bits: saturate without iterating
    assign st_hi  = CMP_W'(st_num >> OUT_W);
    assign st_ovf = (st_hi >= CMP_W'(st_dvs));

    // One restoring step
    assign rem2    = {rem_reg, lo_reg[OUT_W-1]};
    assign step_ge = (rem2 >= {1'b0, dvs_reg});

    // Cap the magnitude, then apply sign with saturation
    assign q_mag = quo_reg[OUT_W-1] ? lbtc_pkg::SAT_MAG : {1'b0, quo_reg};
    always_comb begin
        if (neg_reg) begin
            div_res = OUT_W'((OUT_W + 1)'(0) - q_mag);
        end else if (quo_reg[OUT_W-1]) begin
            div_res = lbtc_pkg::OUT_MAX;
        end else begin
            div_res = $signed(quo_reg);
        end
    end

    // A negative x average flips y; then both go through the zero band
    always_comb begin
        if (xh_reg[OUT_W-1]) begin
            y_cpl = (yh_reg == lbtc_pkg::OUT_MIN) ? lbtc_pkg::OUT_MAX : -yh_reg;
        end else begin
            y_cpl = yh_reg;
        end
        xh_fin = (mag_of(xh_reg) < (OUT_W + 1)'(zb_reg)) ? '0 : xh_reg;
        yh_fin = (mag_of(y_cpl) < (OUT_W + 1)'(zb_reg)) ? '0 : y_cpl;
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        job_next     = job_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        total_next   = total_reg;
        dvs_next     = dvs_reg;
        rem_next     = rem_reg;
        lo_next      = lo_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        xt_next      = xt_reg;
        yt_next      = yt_reg;
        xh_next      = xh_reg;
        yh_next      = yh_reg;
        xsum_next    = xsum_reg;
        ysum_next    = ysum_reg;
        xfill_next   = xfill_reg;
        yfill_next   = yfill_reg;
        xold_next    = xold_reg;
        yold_next    = yold_reg;
        x_we         = 1'b0;
        y_we         = 1'b0;
        x_waddr      = xold_reg;
        y_waddr      = yold_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;

        case (state_reg)
            lbtc_pkg::ST_IDLE: begin
                if (in_fire) begin
                    dx_next = $signed({2'b00, w2}) + $signed({2'b00, w0})
                            - $signed({2'b00, w1}) - $signed({2'b00, w3});
                    dy_next = $signed({2'b00, w2}) + $signed({2'b00, w3})
                            - $signed({2'b00, w1}) - $signed({2'b00, w0});
                    total_next = lbtc_pkg::TOTAL_W'(w0) + lbtc_pkg::TOTAL_W'(w1)
                               + lbtc_pkg::TOTAL_W'(w2) + lbtc_pkg::TOTAL_W'(w3);
                    state_next = lbtc_pkg::ST_TX;
                end
            end

            lbtc_pkg::ST_TX, lbtc_pkg::ST_TY, lbtc_pkg::ST_XAVG, lbtc_pkg::ST_YAVG: begin
                case (state_reg)
                    lbtc_pkg::ST_TX:   job_next = lbtc_pkg::JOB_TX;
                    lbtc_pkg::ST_TY:   job_next = lbtc_pkg::JOB_TY;
                    lbtc_pkg::ST_XAVG: job_next = lbtc_pkg::JOB_XA;
                    default:           job_next = lbtc_pkg::JOB_YA;
                endcase
                if ((state_reg == lbtc_pkg::ST_TX || state_reg == lbtc_pkg::ST_TY)
                    && !t_pass) begin
                    // Inside the deadband or zero total: no division, tilt is zero
                    if (t_is_x) begin
                        xt_next    = '0;
                        state_next = lbtc_pkg::ST_TY;
                    end else begin
                        yt_next    = '0;
                        state_next = lbtc_pkg::ST_XPUSH;
                    end
                end else begin
                    dvs_next = st_dvs;
                    rem_next = st_hi[DVS_W-1:0];
                    lo_next  = st_num[OUT_W-1:0];
                    neg_next = st_neg;
                    cnt_next = '0;
                    if (st_ovf) begin
                        quo_next   = '1;
                        state_next = lbtc_pkg::ST_STORE;
                    end else begin
                        quo_next   = '0;
                        state_next = lbtc_pkg::ST_DIV;
                    end
                end
            end

            lbtc_pkg::ST_DIV: begin
                rem_next = DVS_W'(step_ge ? rem2 - {1'b0, dvs_reg} : rem2);
                lo_next  = lo_reg << 1;
                quo_next = {quo_reg[OUT_W-2:0], step_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(OUT_W - 1)) begin
                    state_next = lbtc_pkg::ST_STORE;
                end
            end

            lbtc_pkg::ST_STORE: begin
                case (job_reg)
                    lbtc_pkg::JOB_TX: begin
                        xt_next    = div_res;
                        state_next = lbtc_pkg::ST_TY;
                    end
                    lbtc_pkg::JOB_TY: begin
                        yt_next    = div_res;
                        state_next = lbtc_pkg::ST_XPUSH;
                    end
                    lbtc_pkg::JOB_XA: begin
                        xh_next    = div_res;
                        state_next = lbtc_pkg::ST_YPUSH;
                    end
                    default: begin
                        yh_next    = div_res;
                        state_next = lbtc_pkg::ST_FINISH;
                    end
                endcase
            end

            lbtc_pkg::ST_XPUSH: begin
                x_we = 1'b1;
                if (xfill_reg < XF_W'(X_WINDOW)) begin
                    // Still filling: average holds
                    xsum_next  = xsum_reg + XS_W'(xt_reg);
                    x_waddr    = xfill_reg[XA_W-1:0];
                    xfill_next = xfill_reg + 1'b1;
                    state_next = lbtc_pkg::ST_YPUSH;
                end else begin
                    xsum_next  = xsum_reg - XS_W'(xrd_reg) + XS_W'(xt_reg);
                    xold_next  = (xold_reg == XA_W'(X_WINDOW - 1)) ? '0
                                                                   : XA_W'(xold_reg + 1'b1);
                    state_next = lbtc_pkg::ST_XAVG;
                end
            end

            lbtc_pkg::ST_YPUSH: begin
                y_we = 1'b1;
                if (yfill_reg < YF_W'(Y_WINDOW)) begin
                    ysum_next  = ysum_reg + YS_W'(yt_reg);
                    y_waddr    = yfill_reg[YA_W-1:0];
                    yfill_next = yfill_reg + 1'b1;
                    state_next = lbtc_pkg::ST_FINISH;
                end else begin
                    ysum_next  = ysum_reg - YS_W'(yrd_reg) + YS_W'(yt_reg);
                    yold_next  = (yold_reg == YA_W'(Y_WINDOW - 1)) ? '0
                                                                   : YA_W'(yold_reg + 1'b1);
                    state_next = lbtc_pkg::ST_YAVG;
                end
            end

            lbtc_pkg::ST_FINISH: begin
                // Wait for the result register, then commit the held averages
                if (out_free) begin
                    xh_next      = xh_fin;
                    yh_next      = yh_fin;
                    m_valid_next = 1'b1;
                    m_data_next  = lbtc_pkg::M_DATA_W'({yh_fin, xh_fin, yt_reg, xt_reg});
                    state_next   = lbtc_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = lbtc_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Control state, windows and configuration
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lbtc_pkg::ST_IDLE;
            job_reg     <= lbtc_pkg::JOB_TX;
            xh_reg      <= '0;
            yh_reg      <= '0;
            xsum_reg    <= '0;
            ysum_reg    <= '0;
            xfill_reg   <= '0;
            yfill_reg   <= '0;
            xold_reg    <= '0;
            yold_reg    <= '0;
            m_valid_reg <= 1'b0;
            x_db_reg    <= lbtc_pkg::X_DEADBAND_RST;
            y_db_reg    <= lbtc_pkg::Y_DEADBAND_RST;
            x_gain_reg  <= lbtc_pkg::X_GAIN_RST;
            y_gain_reg  <= lbtc_pkg::Y_GAIN_RST;
            zb_reg      <= lbtc_pkg::ZERO_BAND_RST;
        end else begin
            state_reg   <= state_next;
            job_reg     <= job_next;
            xh_reg      <= xh_next;
            yh_reg      <= yh_next;
            xsum_reg    <= xsum_next;
            ysum_reg    <= ysum_next;
            xfill_reg   <= xfill_next;
            yfill_reg   <= yfill_next;
            xold_reg    <= xold_next;
            yold_reg    <= yold_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    lbtc_pkg::REG_X_DEADBAND: x_db_reg   <= cfg_wdata;
                    lbtc_pkg::REG_Y_DEADBAND: y_db_reg   <= cfg_wdata;
                    lbtc_pkg::REG_X_GAIN:     x_gain_reg <= cfg_wdata[lbtc_pkg::GAIN_W-1:0];
                    lbtc_pkg::REG_Y_GAIN:     y_gain_reg <= cfg_wdata[lbtc_pkg::GAIN_W-1:0];
                    lbtc_pkg::REG_ZERO_BAND:  zb_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        total_reg  <= total_next;
        dvs_reg    <= dvs_next;
        rem_reg    <= rem_next;
        lo_reg     <= lo_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        xt_reg     <= xt_next;
        yt_reg     <= yt_next;
        m_data_reg <= m_data_next;
    end

    // Window memories: read the oldest entry every cycle, write on push
    always_ff @(posedge aclk) begin
        if (x_we) begin
            xmem[x_waddr] <= xt_reg;
        end
        xrd_reg <= xmem[xold_reg];
    end

    always_ff @(posedge aclk) begin
        if (y_we) begin
            ymem[y_waddr] <= yt_reg;
        end
        yrd_reg <= ymem[yold_reg];
    end

endmodule

// ===== hdl/lbtc_checker.sv =====
// ============================================================================
// lbtc_checker: port-level checks for load_board_tilt_command
// Watches the request and result channels over time.
// ============================================================================
module lbtc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [lbtc_pkg::M_DATA_W-1:0] m_axis_tdata
);

    logic in_fire;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Reset drops the result channel
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Stalled result holds its data
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // One request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("request taken while busy");

    // No result can appear the cycle after an accept
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

endmodule

bind load_board_tilt_command lbtc_checker u_lbtc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
